### rtl/core/seir_pkg.sv
// seir_pkg: shared types, constants and the evolve micro-op table for the
// SEIR vaccination/testing Euler-step block. No dependencies.
`timescale 1ns / 1ps

package seir_pkg;

	localparam int TALLY_FRAC_BITS = 16;
	localparam int NT = 14;
	localparam int TAW = $clog2(NT);
	localparam int TW = 48;
	localparam logic [63:0] ONE_Q24 = 64'h0000_0000_0100_0000;
	localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [TW-1:0] TENTH = TW'(((64'd1 << TALLY_FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [4:0] EV_LAST = 5'd24;

	typedef enum logic [1:0] {
		OP_EVOLVE = 2'd0,
		OP_REPORT = 2'd1,
		OP_VACC   = 2'd2,
		OP_LOAD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_RECIP_POP  = 3'd0,
		CFG_RECIP_INC  = 3'd1,
		CFG_RECIP_REC  = 3'd2,
		CFG_VAC_FAT    = 3'd3,
		CFG_VAC_INF    = 3'd4,
		CFG_TEST_INF   = 3'd5,
		CFG_VAC_SUSC   = 3'd6,
		CFG_TIME_STEP  = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		T_S = 4'd0, T_SV = 4'd1, T_E = 4'd2, T_EV = 4'd3,
		T_I = 4'd4, T_IR = 4'd5, T_IV = 4'd6, T_IVR = 4'd7,
		T_R = 4'd8, T_RV = 4'd9, T_D = 4'd10, T_DV = 4'd11,
		T_REP = 4'd12, T_EXIT = 4'd13
	} tidx_t;

	typedef enum logic [4:0] {
		S_MEM, S_ONE, S_BETA, S_FC, S_OMF, S_FV, S_OMFV, S_RR, S_TH,
		S_VFS, S_VIS, S_TIS, S_VSUS, S_RPOP, S_W, S_T0, S_LAM, S_LAMV,
		S_GAM, S_MU, S_GAMV, S_MUV
	} src_t;

	typedef enum logic [4:0] {
		D_FV, D_GAM, D_MU, D_GAMV, D_MUV, D_W, D_WADD, D_T0, D_LAM, D_LAMV,
		D_INFS, D_INFSV, D_INCE, D_INCEV, D_RI, D_DI, D_RIR, D_DIR,
		D_RIV, D_DIV, D_RIVR, D_DIVR
	} dst_t;

	typedef enum logic [1:0] {
		SH_24, SH_48, SH_FRAC
	} sh_t;

	typedef enum logic [2:0] {
		MV_0, MV_1, MV_2, MV_3, MV_4, MV_SUM01
	} mvsel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_EV_RD, ST_EV_LD, ST_MUL, ST_EV_RES, ST_WB_RD, ST_WB_WR,
		ST_SUM_RD, ST_SUM_ACC, ST_SH_RD, ST_SH_LD, ST_DIV, ST_SH_END,
		ST_MV_RD, ST_MV_WR, ST_EM_RD, ST_EM_CAP
	} state_t;

	typedef struct packed {
		src_t  a;
		src_t  b;
		tidx_t addr;
		sh_t   sh;
		logic  dt;
		dst_t  dst;
	} uop_t;

	typedef struct packed {
		tidx_t  addr;
		mvsel_t dsel;
		logic   sub;
	} mv_ent_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] infection_rate;
		logic [24:0] fatality_fraction;
		logic        freeze_susceptible;
		logic [47:0] tests_today;
		logic [47:0] vaccinations_today;
		logic [3:0]  load_index;
		logic [47:0] load_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  tally_index;
		logic [47:0] tally_value;
		logic        last_tally;
	} tally_t;

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] msh(input logic [127:0] p, input sh_t sh);
		logic [127:0] s;
		case (sh)
			SH_24:   s = p >> 24;
			SH_48:   s = p >> 48;
			default: s = p >> TALLY_FRAC_BITS;
		endcase
		return (s[127:64] != 64'd0) ? '1 : s[63:0];
	endfunction

	function automatic uop_t ev_uop(input logic [4:0] i);
		uop_t u;
		case (i)
			5'd0:    u = '{S_VFS,  S_FC,   T_S,   SH_24,   1'b0, D_FV};
			5'd1:    u = '{S_RR,   S_OMF,  T_S,   SH_24,   1'b0, D_GAM};
			5'd2:    u = '{S_RR,   S_FC,   T_S,   SH_24,   1'b0, D_MU};
			5'd3:    u = '{S_RR,   S_OMFV, T_S,   SH_24,   1'b0, D_GAMV};
			5'd4:    u = '{S_RR,   S_FV,   T_S,   SH_24,   1'b0, D_MUV};
			5'd5:    u = '{S_MEM,  S_ONE,  T_I,   SH_24,   1'b0, D_W};
			5'd6:    u = '{S_TIS,  S_MEM,  T_IR,  SH_24,   1'b0, D_WADD};
			5'd7:    u = '{S_VIS,  S_MEM,  T_IV,  SH_24,   1'b0, D_WADD};
			5'd8:    u = '{S_TIS,  S_VIS,  T_S,   SH_24,   1'b0, D_T0};
			5'd9:    u = '{S_T0,   S_MEM,  T_IVR, SH_24,   1'b0, D_WADD};
			5'd10:   u = '{S_W,    S_RPOP, T_S,   SH_FRAC, 1'b0, D_T0};
			5'd11:   u = '{S_BETA, S_T0,   T_S,   SH_24,   1'b0, D_LAM};
			5'd12:   u = '{S_VSUS, S_LAM,  T_S,   SH_24,   1'b0, D_LAMV};
			5'd13:   u = '{S_MEM,  S_LAM,  T_S,   SH_48,   1'b1, D_INFS};
			5'd14:   u = '{S_MEM,  S_LAMV, T_SV,  SH_48,   1'b1, D_INFSV};
			5'd15:   u = '{S_TH,   S_MEM,  T_E,   SH_24,   1'b1, D_INCE};
			5'd16:   u = '{S_TH,   S_MEM,  T_EV,  SH_24,   1'b1, D_INCEV};
			5'd17:   u = '{S_GAM,  S_MEM,  T_I,   SH_24,   1'b1, D_RI};
			5'd18:   u = '{S_MU,   S_MEM,  T_I,   SH_24,   1'b1, D_DI};
			5'd19:   u = '{S_GAM,  S_MEM,  T_IR,  SH_24,   1'b1, D_RIR};
			5'd20:   u = '{S_MU,   S_MEM,  T_IR,  SH_24,   1'b1, D_DIR};
			5'd21:   u = '{S_GAMV, S_MEM,  T_IV,  SH_24,   1'b1, D_RIV};
			5'd22:   u = '{S_MUV,  S_MEM,  T_IV,  SH_24,   1'b1, D_DIV};
			5'd23:   u = '{S_GAMV, S_MEM,  T_IVR, SH_24,   1'b1, D_RIVR};
			default: u = '{S_MUV,  S_MEM,  T_IVR, SH_24,   1'b1, D_DIVR};
		endcase
		return u;
	endfunction

	function automatic logic [3:0] tot_last(input op_t op);
		return (op == OP_REPORT) ? 4'd5 : 4'd4;
	endfunction

	function automatic logic [3:0] shr_last(input op_t op);
		return (op == OP_REPORT) ? 4'd1 : 4'd4;
	endfunction

	function automatic logic [3:0] mv_last(input op_t op);
		return (op == OP_REPORT) ? 4'd4 : 4'd9;
	endfunction

	function automatic tidx_t tot_addr(input op_t op, input logic [3:0] j);
		tidx_t t;
		if (op == OP_REPORT) begin
			case (j)
				4'd0:    t = T_S;
				4'd1:    t = T_SV;
				4'd2:    t = T_E;
				4'd3:    t = T_EV;
				4'd4:    t = T_I;
				default: t = T_IV;
			endcase
		end else begin
			case (j)
				4'd0:    t = T_S;
				4'd1:    t = T_E;
				4'd2:    t = T_I;
				4'd3:    t = T_IR;
				default: t = T_R;
			endcase
		end
		return t;
	endfunction

	function automatic tidx_t shr_addr(input op_t op, input logic [3:0] j);
		tidx_t t;
		if (op == OP_REPORT) begin
			t = (j == 4'd0) ? T_I : T_IV;
		end else begin
			case (j)
				4'd0:    t = T_S;
				4'd1:    t = T_E;
				4'd2:    t = T_I;
				4'd3:    t = T_IR;
				default: t = T_R;
			endcase
		end
		return t;
	endfunction

	function automatic mv_ent_t mv_entry(input op_t op, input logic [3:0] j);
		mv_ent_t e;
		if (op == OP_REPORT) begin
			case (j)
				4'd0:    e = '{T_I,   MV_0,     1'b1};
				4'd1:    e = '{T_IR,  MV_0,     1'b0};
				4'd2:    e = '{T_IV,  MV_1,     1'b1};
				4'd3:    e = '{T_IVR, MV_1,     1'b0};
				default: e = '{T_REP, MV_SUM01, 1'b0};
			endcase
		end else begin
			case (j)
				4'd0:    e = '{T_S,   MV_0, 1'b1};
				4'd1:    e = '{T_SV,  MV_0, 1'b0};
				4'd2:    e = '{T_E,   MV_1, 1'b1};
				4'd3:    e = '{T_EV,  MV_1, 1'b0};
				4'd4:    e = '{T_I,   MV_2, 1'b1};
				4'd5:    e = '{T_IV,  MV_2, 1'b0};
				4'd6:    e = '{T_IR,  MV_3, 1'b1};
				4'd7:    e = '{T_IVR, MV_3, 1'b0};
				4'd8:    e = '{T_R,   MV_4, 1'b1};
				default: e = '{T_RV,  MV_4, 1'b0};
			endcase
		end
		return e;
	endfunction

endpackage

### rtl/core/seir_vaccine_euler_step.sv
// seir_vaccine_euler_step: top level of the SEIR Euler-step block.
// Depends on seir_pkg and seir_ram.
`timescale 1ns / 1ps

// Fourteen Q32.16 tallies live in a 14x48 RAM (zero after reset through
// per-entry valid bits). Every transaction runs to completion before the next
// is taken, then all fourteen tallies go out in index order. The shared 64x64
// multiplier sums four 32x32 partial products, one per cycle, and the shared
// divider makes one quotient bit per cycle. Evolve does 25 multiplies, 12 of
// them followed by a time-step multiply, then a 13-entry read-modify-write
// pass; report does two divisions and vaccinate five.
module seir_vaccine_euler_step import seir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        tally_valid,
	input  logic        tally_stall,
	output tally_t      tally,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	state_t state_q, state_d;

	logic [47:0] recip_population_q;
	logic [31:0] recip_incubation_q, recip_recovery_q, vac_fat_q, vac_inf_q;
	logic [31:0] test_inf_q, vac_susc_q, time_step_q;

	op_t         op_q;
	logic [31:0] beta_q;
	logic [24:0] f_q;
	logic        frz_q;
	logic [47:0] n_q;

	logic [4:0]   uop_q;
	logic         pass_q;
	logic [1:0]   mcnt_q;
	logic [6:0]   dcnt_q;
	logic [3:0]   k_q, j_q;
	logic [63:0]  ma_q, mb_q;
	logic [127:0] prod_q;
	logic [51:0]  tot_q, rem_q;
	logic [47:0]  x_q;
	logic [63:0]  quo_q;
	logic         ovf_q;
	logic [47:0]  mv_q [5];

	logic [24:0] fv_q;
	logic [31:0] gam_q, mu_q, gamv_q, muv_q;
	logic [63:0] w_q, t0_q, lam_q, lamv_q, infs_q, infsv_q, ince_q, incev_q;
	logic [63:0] ri_q, di_q, rir_q, dir_q, riv_q, div_q, rivr_q, divr_q;
	logic [63:0] gain_s1, loss_s1;

	logic        tally_valid_q;
	tally_t      tally_q;
	logic [NT-1:0] valid_q;
	logic        rvalid_q;

	logic            ram_we, ram_re;
	logic [TAW-1:0]  ram_waddr, ram_raddr;
	logic [TW-1:0]   ram_wdata, ram_rdata, rd;

	logic   accept, em_take;
	uop_t   uop;
	mv_ent_t mve;

	seir_ram #(.WIDTH(TW), .DEPTH(NT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd = rvalid_q ? ram_rdata : '0;

	assign item_stall  = (state_q != ST_IDLE);
	assign accept      = item_valid && !item_stall;
	assign tally_valid = tally_valid_q;
	assign tally       = tally_q;
	assign em_take     = (state_q == ST_EM_CAP) && (!tally_valid_q || !tally_stall);
	assign uop         = ev_uop(uop_q);
	assign mve         = mv_entry(op_q, j_q);

	// operands
	logic [24:0] fc;
	assign fc = (f_q > 25'(ONE_Q24)) ? 25'(ONE_Q24) : f_q;

	function automatic logic [63:0] srcv(input src_t s);
		logic [63:0] v;
		case (s)
			S_MEM:   v = {16'd0, rd};
			S_ONE:   v = ONE_Q24;
			S_BETA:  v = {32'd0, beta_q};
			S_FC:    v = {39'd0, fc};
			S_OMF:   v = ONE_Q24 - {39'd0, fc};
			S_FV:    v = {39'd0, fv_q};
			S_OMFV:  v = ONE_Q24 - {39'd0, fv_q};
			S_RR:    v = {32'd0, recip_recovery_q};
			S_TH:    v = {32'd0, recip_incubation_q};
			S_VFS:   v = {32'd0, vac_fat_q};
			S_VIS:   v = {32'd0, vac_inf_q};
			S_TIS:   v = {32'd0, test_inf_q};
			S_VSUS:  v = {32'd0, vac_susc_q};
			S_RPOP:  v = {16'd0, recip_population_q};
			S_W:     v = w_q;
			S_T0:    v = t0_q;
			S_LAM:   v = lam_q;
			S_LAMV:  v = lamv_q;
			S_GAM:   v = {32'd0, gam_q};
			S_MU:    v = {32'd0, mu_q};
			S_GAMV:  v = {32'd0, gamv_q};
			default: v = {32'd0, muv_q};
		endcase
		return v;
	endfunction

	// multiplier partial product
	logic [31:0]  pa, pb;
	logic [63:0]  pm;
	logic [127:0] ppw;
	assign pa = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pm = pa * pb;
	always_comb begin
		unique case (mcnt_q)
			2'd0:    ppw = {64'd0, pm};
			2'd3:    ppw = {pm, 64'd0};
			default: ppw = {32'd0, pm, 32'd0};
		endcase
	end

	logic [63:0] mres;
	assign mres = msh(prod_q, pass_q ? SH_24 : uop.sh);

	// divider step
	logic [52:0] rn, rdiff;
	logic        ge;
	assign rn    = {rem_q, prod_q[127]};
	assign ge    = rn >= {1'b0, tot_q};
	assign rdiff = rn - {1'b0, tot_q};

	logic [51:0] tot_sum;
	assign tot_sum = tot_q + {4'd0, rd};

	// evolve write-back flows
	logic [63:0] infs_e, infsv_e, gain_c, loss_c;
	assign infs_e  = frz_q ? 64'd0 : infs_q;
	assign infsv_e = frz_q ? 64'd0 : infsv_q;

	always_comb begin
		gain_c = '0;
		loss_c = '0;
		case (tidx_t'(k_q))
			T_S:    loss_c = infs_e;
			T_SV:   loss_c = infsv_e;
			T_E:    begin gain_c = infs_e;  loss_c = ince_q;  end
			T_EV:   begin gain_c = infsv_e; loss_c = incev_q; end
			T_I:    begin gain_c = ince_q;  loss_c = sadd(ri_q, di_q); end
			T_IR:   loss_c = sadd(rir_q, dir_q);
			T_IV:   begin gain_c = incev_q; loss_c = sadd(riv_q, div_q); end
			T_IVR:  loss_c = sadd(rivr_q, divr_q);
			T_R:    gain_c = sadd(ri_q, rir_q);
			T_RV:   gain_c = sadd(riv_q, rivr_q);
			T_D:    gain_c = sadd(di_q, dir_q);
			T_DV:   gain_c = sadd(div_q, divr_q);
			T_EXIT: gain_c = sadd(infs_q, infsv_q);
			default: ;
		endcase
	end

	logic [63:0] wb_a, wb_v;
	logic [47:0] wb_sat, wb_val;
	assign wb_a   = sadd({16'd0, rd}, gain_s1);
	assign wb_v   = (loss_s1 > wb_a) ? 64'd0 : wb_a - loss_s1;
	assign wb_sat = (wb_v > MAX48) ? MAX48[47:0] : wb_v[47:0];
	assign wb_val = (((tidx_t'(k_q) == T_E) || (tidx_t'(k_q) == T_EV)) && (wb_sat < TENTH))
		? 48'd0 : wb_sat;

	// share/move arithmetic
	logic [48:0] mvd;
	logic [49:0] mv_sum;
	logic [47:0] mv_val, shr_val;
	always_comb begin
		unique case (mve.dsel)
			MV_0:     mvd = {1'b0, mv_q[0]};
			MV_1:     mvd = {1'b0, mv_q[1]};
			MV_2:     mvd = {1'b0, mv_q[2]};
			MV_3:     mvd = {1'b0, mv_q[3]};
			MV_4:     mvd = {1'b0, mv_q[4]};
			default:  mvd = {1'b0, mv_q[0]} + {1'b0, mv_q[1]};
		endcase
	end
	assign mv_sum  = {2'd0, rd} + {1'b0, mvd};
	assign mv_val  = mve.sub ? (rd - mvd[47:0])
		: ((mv_sum[49:48] != 2'd0) ? MAX48[47:0] : mv_sum[47:0]);
	assign shr_val = (ovf_q || (quo_q > {16'd0, x_q})) ? x_q : quo_q[47:0];

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(item.opcode))
						OP_LOAD: begin
							ram_we    = (item.load_index < 4'(NT));
							ram_waddr = item.load_index;
							ram_wdata = item.load_value;
							state_d   = ST_EM_RD;
						end
						OP_EVOLVE: state_d = ST_EV_RD;
						OP_REPORT, OP_VACC: state_d = ST_SUM_RD;
					endcase
				end
			end
			ST_EV_RD: begin
				ram_re    = 1'b1;
				ram_raddr = uop.addr;
				state_d   = ST_EV_LD;
			end
			ST_EV_LD: state_d = ST_MUL;
			ST_MUL: begin
				if (mcnt_q == 2'd3) begin
					state_d = (op_q == OP_EVOLVE) ? ST_EV_RES : ST_DIV;
				end
			end
			ST_EV_RES: begin
				if (uop.dt && !pass_q) begin
					state_d = ST_MUL;
				end else if (uop_q == EV_LAST) begin
					state_d = ST_WB_RD;
				end else begin
					state_d = ST_EV_RD;
				end
			end
			ST_WB_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				state_d   = ST_WB_WR;
			end
			ST_WB_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = wb_val;
				state_d   = (tidx_t'(k_q) == T_EXIT) ? ST_EM_RD : ST_WB_RD;
			end
			ST_SUM_RD: begin
				ram_re    = 1'b1;
				ram_raddr = tot_addr(op_q, j_q);
				state_d   = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				if (j_q == tot_last(op_q)) begin
					state_d = ((tot_sum == '0) || (n_q == '0)) ? ST_EM_RD : ST_SH_RD;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_SH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = shr_addr(op_q, j_q);
				state_d   = ST_SH_LD;
			end
			ST_SH_LD: state_d = ST_MUL;
			ST_DIV: begin
				if (dcnt_q == '1) begin
					state_d = ST_SH_END;
				end
			end
			ST_SH_END: state_d = (j_q == shr_last(op_q)) ? ST_MV_RD : ST_SH_RD;
			ST_MV_RD: begin
				ram_re    = 1'b1;
				ram_raddr = mve.addr;
				state_d   = ST_MV_WR;
			end
			ST_MV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = mve.addr;
				ram_wdata = mv_val;
				state_d   = (j_q == mv_last(op_q)) ? ST_EM_RD : ST_MV_RD;
			end
			ST_EM_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				state_d   = ST_EM_CAP;
			end
			ST_EM_CAP: begin
				if (em_take) begin
					state_d = (tidx_t'(k_q) == T_EXIT) ? ST_IDLE : ST_EM_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			uop_q              <= '0;
			pass_q             <= 1'b0;
			mcnt_q             <= '0;
			dcnt_q             <= '0;
			k_q                <= '0;
			j_q                <= '0;
			tally_valid_q      <= 1'b0;
			valid_q            <= '0;
			rvalid_q           <= 1'b0;
			recip_population_q <= '0;
			recip_incubation_q <= '0;
			recip_recovery_q   <= '0;
			vac_fat_q          <= ONE_Q24[31:0];
			vac_inf_q          <= ONE_Q24[31:0];
			test_inf_q         <= ONE_Q24[31:0];
			vac_susc_q         <= ONE_Q24[31:0];
			time_step_q        <= ONE_Q24[31:0];
		end else begin
			state_q <= state_d;
			mcnt_q  <= (state_q == ST_MUL) ? mcnt_q + 2'd1 : 2'd0;
			dcnt_q  <= (state_q == ST_DIV) ? dcnt_q + 7'd1 : 7'd0;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rvalid_q <= valid_q[ram_raddr];
			end
			if (accept) begin
				uop_q <= '0;
				k_q   <= '0;
				j_q   <= '0;
			end
			if (state_q == ST_EV_RES) begin
				pass_q <= uop.dt && !pass_q;
				if (!(uop.dt && !pass_q)) begin
					uop_q <= uop_q + 5'd1;
				end
			end
			if (state_q == ST_WB_WR) begin
				if (tidx_t'(k_q) == T_EXIT) begin
					k_q <= '0;
				end else if (tidx_t'(k_q) == T_DV) begin
					k_q <= T_EXIT;
				end else begin
					k_q <= k_q + 4'd1;
				end
			end
			if (state_q == ST_SUM_ACC) begin
				j_q <= (j_q == tot_last(op_q)) ? 4'd0 : j_q + 4'd1;
			end
			if (state_q == ST_SH_END) begin
				j_q <= (j_q == shr_last(op_q)) ? 4'd0 : j_q + 4'd1;
			end
			if (state_q == ST_MV_WR) begin
				j_q <= j_q + 4'd1;
			end
			if (em_take) begin
				k_q <= k_q + 4'd1;
			end
			if (em_take) begin
				tally_valid_q <= 1'b1;
			end else if (tally_valid_q && !tally_stall) begin
				tally_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_RECIP_POP: recip_population_q <= cfg_data;
					CFG_RECIP_INC: recip_incubation_q <= cfg_data[31:0];
					CFG_RECIP_REC: recip_recovery_q   <= cfg_data[31:0];
					CFG_VAC_FAT:   vac_fat_q          <= cfg_data[31:0];
					CFG_VAC_INF:   vac_inf_q          <= cfg_data[31:0];
					CFG_TEST_INF:  test_inf_q         <= cfg_data[31:0];
					CFG_VAC_SUSC:  vac_susc_q         <= cfg_data[31:0];
					CFG_TIME_STEP: time_step_q        <= cfg_data[31:0];
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(item.opcode);
			beta_q <= item.infection_rate;
			f_q    <= item.fatality_fraction;
			frz_q  <= item.freeze_susceptible;
			n_q    <= (op_t'(item.opcode) == OP_REPORT) ? item.tests_today
				: item.vaccinations_today;
			tot_q  <= '0;
		end
		unique case (state_q)
			ST_EV_LD: begin
				ma_q   <= srcv(uop.a);
				mb_q   <= srcv(uop.b);
				prod_q <= '0;
			end
			ST_SH_LD: begin
				x_q    <= rd;
				ma_q   <= {16'd0, rd};
				mb_q   <= {16'd0, n_q};
				prod_q <= '0;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
			end
			ST_MUL: prod_q <= prod_q + ppw;
			ST_EV_RES: begin
				if (uop.dt && !pass_q) begin
					ma_q   <= mres;
					mb_q   <= {32'd0, time_step_q};
					prod_q <= '0;
				end else begin
					unique case (uop.dst)
						D_FV:    fv_q    <= (mres > ONE_Q24) ? 25'(ONE_Q24) : mres[24:0];
						D_GAM:   gam_q   <= mres[31:0];
						D_MU:    mu_q    <= mres[31:0];
						D_GAMV:  gamv_q  <= mres[31:0];
						D_MUV:   muv_q   <= mres[31:0];
						D_W:     w_q     <= mres;
						D_WADD:  w_q     <= sadd(w_q, mres);
						D_T0:    t0_q    <= mres;
						D_LAM:   lam_q   <= mres;
						D_LAMV:  lamv_q  <= mres;
						D_INFS:  infs_q  <= mres;
						D_INFSV: infsv_q <= mres;
						D_INCE:  ince_q  <= mres;
						D_INCEV: incev_q <= mres;
						D_RI:    ri_q    <= mres;
						D_DI:    di_q    <= mres;
						D_RIR:   rir_q   <= mres;
						D_DIR:   dir_q   <= mres;
						D_RIV:   riv_q   <= mres;
						D_DIV:   div_q   <= mres;
						D_RIVR:  rivr_q  <= mres;
						default: divr_q  <= mres;
					endcase
				end
			end
			ST_WB_RD: begin
				gain_s1 <= gain_c;
				loss_s1 <= loss_c;
			end
			ST_SUM_ACC: tot_q <= tot_sum;
			ST_DIV: begin
				prod_q <= {prod_q[126:0], 1'b0};
				rem_q  <= ge ? rdiff[51:0] : rn[51:0];
				ovf_q  <= ovf_q | quo_q[63];
				quo_q  <= {quo_q[62:0], ge};
			end
			ST_SH_END: mv_q[j_q[2:0]] <= shr_val;
			ST_EM_CAP: begin
				if (em_take) begin
					tally_q.tally_index <= k_q;
					tally_q.tally_value <= rd;
					tally_q.last_tally  <= (tidx_t'(k_q) == T_EXIT);
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		tally_valid && tally.last_tally |-> tally.tally_index == T_EXIT)
		else $error("last tally flag on wrong index");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (tot_q != '0))
		else $error("division by zero total");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < 4'(NT)))
		else $error("tally write out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EM_RD) || (state_q == ST_EM_CAP)) |-> !ram_we)
		else $error("tally store written during output");

endmodule

### rtl/core/seir_ram.sv
// seir_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`timescale 1ns / 1ps

module seir_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
